>>> rtl/ccl_pkg.sv
// shared types, codes and calendar helpers for the calendar clock
package ccl_pkg;

   // transaction kinds
   localparam logic [2:0] KIND_TICK     = 3'd0;
   localparam logic [2:0] KIND_SET_DATE = 3'd1;
   localparam logic [2:0] KIND_SET_TIME = 3'd2;
   localparam logic [2:0] KIND_SET_BOTH = 3'd3;
   localparam logic [2:0] KIND_READ     = 3'd4;

   // result status codes
   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   // month numbers
   localparam logic [3:0] MONTH_JAN = 4'd1;
   localparam logic [3:0] MONTH_FEB = 4'd2;
   localparam logic [3:0] MONTH_MAR = 4'd3;
   localparam logic [3:0] MONTH_APR = 4'd4;
   localparam logic [3:0] MONTH_MAY = 4'd5;
   localparam logic [3:0] MONTH_JUN = 4'd6;
   localparam logic [3:0] MONTH_JUL = 4'd7;
   localparam logic [3:0] MONTH_AUG = 4'd8;
   localparam logic [3:0] MONTH_SEP = 4'd9;
   localparam logic [3:0] MONTH_OCT = 4'd10;
   localparam logic [3:0] MONTH_NOV = 4'd11;
   localparam logic [3:0] MONTH_DEC = 4'd12;

   // divisibility by 25 via the multiplicative inverse modulo 2^16
   localparam logic [15:0] INV_25      = 16'd23593;
   localparam logic [15:0] DIV25_LIMIT = 16'd2621;

   // reset calendar: 18 june 2022, 20:00:00
   localparam logic [15:0] RESET_YEAR  = 16'd2022;
   localparam logic [3:0]  RESET_MONTH = MONTH_JUN;
   localparam logic [4:0]  RESET_DAY   = 5'd18;
   localparam logic [1:0]  RESET_HOUR_TENS = 2'd2;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] new_year;
      logic [3:0]  new_month;
      logic [4:0]  new_day;
      logic [4:0]  new_hour;
      logic [5:0]  new_minute;
      logic [5:0]  new_second;
   } req_type;

   typedef struct packed {
      logic [15:0] year_now;
      logic [3:0]  month_now;
      logic [4:0]  day_now;
      logic [1:0]  hour_tens;
      logic [3:0]  hour_ones;
      logic [2:0]  minute_tens;
      logic [3:0]  minute_ones;
      logic [2:0]  second_tens;
      logic [3:0]  second_ones;
      logic        status;
   } rsp_type;

   typedef struct packed {
      logic [15:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
   } date_type;

   typedef struct packed {
      logic [1:0] hour_tens;
      logic [3:0] hour_ones;
      logic [2:0] minute_tens;
      logic [3:0] minute_ones;
      logic [2:0] second_tens;
      logic [3:0] second_ones;
   } time_type;

   typedef struct packed {
      logic [2:0] tens;
      logic [3:0] ones;
   } digits_type;

   typedef struct packed {
      date_type advanced;
      date_type loaded;
      logic     ok;
   } date_res_type;

   typedef struct packed {
      time_type ticked;
      time_type loaded;
      logic     wrap;
      logic     ok;
   } time_res_type;

   // gregorian leap year: divisible by 4, and by 16 whenever divisible by 25
   function automatic logic is_leap(input logic [15:0] y);
      logic [31:0] prod;
      logic        div25;
      prod  = y * INV_25;
      div25 = (prod[15:0] <= DIV25_LIMIT);
      return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
   endfunction

   function automatic logic is_long_month(input logic [3:0] m);
      return (m == MONTH_JAN) || (m == MONTH_MAR) || (m == MONTH_MAY) ||
             (m == MONTH_JUL) || (m == MONTH_AUG) || (m == MONTH_OCT) ||
             (m == MONTH_DEC);
   endfunction

   function automatic logic is_short_month(input logic [3:0] m);
      return (m == MONTH_APR) || (m == MONTH_JUN) || (m == MONTH_SEP) ||
             (m == MONTH_NOV);
   endfunction

   // split a value below 64 into decimal digits
   function automatic digits_type to_digits(input logic [5:0] v);
      digits_type r;
      logic [5:0] rem;
      if (v >= 6'd60)      r.tens = 3'd6;
      else if (v >= 6'd50) r.tens = 3'd5;
      else if (v >= 6'd40) r.tens = 3'd4;
      else if (v >= 6'd30) r.tens = 3'd3;
      else if (v >= 6'd20) r.tens = 3'd2;
      else if (v >= 6'd10) r.tens = 3'd1;
      else                 r.tens = 3'd0;
      rem    = v - 6'({3'd0, r.tens} * 6'd10);
      r.ones = rem[3:0];
      return r;
   endfunction

endpackage

>>> rtl/ccl_stream_if.sv
// valid/ready channel carrying one payload per transaction
interface ccl_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/ccl_time_next.sv
// next time of day for a tick and for a set request
module ccl_time_next (
   input  ccl_pkg::time_type     cur_time,
   input  ccl_pkg::req_type      req,
   output ccl_pkg::time_res_type res
);
   import ccl_pkg::*;

   digits_type hour_dig;
   digits_type minute_dig;
   digits_type second_dig;
   logic       sec_carry;
   logic       min_carry;
   logic       last_hour;

   always_comb begin
      hour_dig   = to_digits({1'b0, req.new_hour});
      minute_dig = to_digits(req.new_minute);
      second_dig = to_digits(req.new_second);

      res.ok = (req.new_hour <= 5'd23) && (req.new_minute <= 6'd59) &&
               (req.new_second <= 6'd59);
      res.loaded.hour_tens   = hour_dig.tens[1:0];
      res.loaded.hour_ones   = hour_dig.ones;
      res.loaded.minute_tens = minute_dig.tens;
      res.loaded.minute_ones = minute_dig.ones;
      res.loaded.second_tens = second_dig.tens;
      res.loaded.second_ones = second_dig.ones;

      // digit counter cascade
      res.ticked = cur_time;
      sec_carry  = (cur_time.second_tens == 3'd5) && (cur_time.second_ones == 4'd9);
      min_carry  = sec_carry && (cur_time.minute_tens == 3'd5) &&
                   (cur_time.minute_ones == 4'd9);
      last_hour  = (cur_time.hour_tens == 2'd2) && (cur_time.hour_ones == 4'd3);
      res.wrap   = min_carry && last_hour;

      if (cur_time.second_ones != 4'd9) begin
         res.ticked.second_ones = cur_time.second_ones + 4'd1;
      end else begin
         res.ticked.second_ones = 4'd0;
         res.ticked.second_tens = sec_carry ? 3'd0 : cur_time.second_tens + 3'd1;
      end

      if (sec_carry) begin
         if (cur_time.minute_ones != 4'd9) begin
            res.ticked.minute_ones = cur_time.minute_ones + 4'd1;
         end else begin
            res.ticked.minute_ones = 4'd0;
            res.ticked.minute_tens = min_carry ? 3'd0 : cur_time.minute_tens + 3'd1;
         end
      end

      if (min_carry) begin
         if (last_hour) begin
            res.ticked.hour_tens = 2'd0;
            res.ticked.hour_ones = 4'd0;
         end else if (cur_time.hour_ones == 4'd9) begin
            res.ticked.hour_tens = cur_time.hour_tens + 2'd1;
            res.ticked.hour_ones = 4'd0;
         end else begin
            res.ticked.hour_ones = cur_time.hour_ones + 4'd1;
         end
      end
   end

endmodule

>>> rtl/ccl_date_next.sv
// next date for a day rollover and the check of a set date request
module ccl_date_next (
   input  ccl_pkg::date_type     cur_date,
   input  ccl_pkg::req_type      req,
   output ccl_pkg::date_res_type res
);
   import ccl_pkg::*;

   logic cur_leap;
   logic new_leap;

   always_comb begin
      cur_leap = is_leap(cur_date.year);
      new_leap = is_leap(req.new_year);

      res.loaded.year  = req.new_year;
      res.loaded.month = req.new_month;
      res.loaded.day   = req.new_day;
      res.ok = !(is_short_month(req.new_month) && (req.new_day == 5'd31)) &&
               !((req.new_month == MONTH_FEB) &&
                 ((req.new_day == 5'd30) || (req.new_day == 5'd31))) &&
               !((req.new_month == MONTH_FEB) && (req.new_day == 5'd29) && !new_leap);

      // months outside 1 to 12 and february past 29 keep the date as it is
      res.advanced = cur_date;
      if (is_long_month(cur_date.month)) begin
         if (cur_date.day < 5'd31) begin
            res.advanced.day = cur_date.day + 5'd1;
         end else if (cur_date.month != MONTH_DEC) begin
            res.advanced.month = cur_date.month + 4'd1;
            res.advanced.day   = 5'd1;
         end else begin
            res.advanced.month = MONTH_JAN;
            res.advanced.day   = 5'd1;
            res.advanced.year  = cur_date.year + 16'd1;
         end
      end else if (is_short_month(cur_date.month)) begin
         if (cur_date.day < 5'd30) begin
            res.advanced.day = cur_date.day + 5'd1;
         end else begin
            res.advanced.month = cur_date.month + 4'd1;
            res.advanced.day   = 5'd1;
         end
      end else if (cur_date.month == MONTH_FEB) begin
         if (cur_date.day < 5'd28) begin
            res.advanced.day = cur_date.day + 5'd1;
         end else if ((cur_date.day == 5'd28) && cur_leap) begin
            res.advanced.day = 5'd29;
         end else if ((cur_date.day == 5'd28) || (cur_date.day == 5'd29)) begin
            res.advanced.month = MONTH_MAR;
            res.advanced.day   = 5'd1;
         end
      end
   end

endmodule

>>> rtl/ccl_rsp_skid.sv
// two-entry result buffer: output register plus skid entry
module ccl_rsp_skid (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  ccl_pkg::rsp_type      in_data,
   output logic                  in_room,
   ccl_stream_if.source          rsp_chan
);
   import ccl_pkg::*;

   logic    out_valid_ff;
   rsp_type out_data_ff;
   logic    skid_valid_ff;
   rsp_type skid_data_ff;
   logic    take;

   assign take           = out_valid_ff && rsp_chan.ready;
   assign in_room        = !skid_valid_ff;
   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (in_valid) begin
         if (out_valid_ff && !take) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end else if (take) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (in_valid) begin
         if (out_valid_ff && !take) begin
            skid_data_ff <= in_data;
         end else begin
            out_data_ff <= in_data;
         end
      end
   end

endmodule

>>> rtl/calendar_clock_with_leap_years.sv
// calendar clock top level: date and time state, request decode, result buffer
//
// keeps a gregorian date (year, month, day) and a time of day held as decimal
// digit counters, starting from 18 june 2022, 20:00:00 after reset. each
// request transaction is one of: tick (one second, rolling the date over at
// midnight), set date, set time, set date and time (written only when every
// check passes, otherwise status 1 and nothing changes) or read; the unused
// kind codes act as a read. every request gives exactly one response carrying
// the date and time after it, with the time as digit pairs. one request is
// taken per clock cycle while request ready is high, and its response is
// registered in the response buffer; all the work is a single combinational
// pass from the held state and the request to the state and response
// registers. a two-entry response buffer lets one further request in while a
// response waits, then request ready drops until the waiting response is taken
// and the skid entry moves up to the output register
module calendar_clock_with_leap_years (
   input logic          clock,
   input logic          reset,
   ccl_stream_if.sink   req_chan,
   ccl_stream_if.source rsp_chan
);
   import ccl_pkg::*;

   // held calendar state
   date_type date_ff;
   date_type date_in;
   time_type time_ff;
   time_type time_in;

   date_res_type date_res;
   time_res_type time_res;
   req_type      req;
   rsp_type      rsp_in;
   logic         status_in;
   logic         accept;
   logic         room;

   assign req             = req_chan.data;
   assign req_chan.ready  = room;
   assign accept          = req_chan.valid && room;

   ccl_date_next u_date_next (
      .cur_date (date_ff),
      .req      (req),
      .res      (date_res)
   );

   ccl_time_next u_time_next (
      .cur_time (time_ff),
      .req      (req),
      .res      (time_res)
   );

   // request decode
   always_comb begin
      date_in   = date_ff;
      time_in   = time_ff;
      status_in = STATUS_OK;
      case (req.kind)
         KIND_TICK: begin
            time_in = time_res.ticked;
            if (time_res.wrap) begin
               date_in = date_res.advanced;
            end
         end
         KIND_SET_DATE: begin
            if (date_res.ok) date_in = date_res.loaded;
            else             status_in = STATUS_REJECT;
         end
         KIND_SET_TIME: begin
            if (time_res.ok) time_in = time_res.loaded;
            else             status_in = STATUS_REJECT;
         end
         KIND_SET_BOTH: begin
            // both checks must pass or nothing is written
            if (date_res.ok && time_res.ok) begin
               date_in = date_res.loaded;
               time_in = time_res.loaded;
            end else begin
               status_in = STATUS_REJECT;
            end
         end
         default: begin
            // read and unused kinds leave the state alone
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         date_ff.year          <= RESET_YEAR;
         date_ff.month         <= RESET_MONTH;
         date_ff.day           <= RESET_DAY;
         time_ff.hour_tens     <= RESET_HOUR_TENS;
         time_ff.hour_ones     <= 4'd0;
         time_ff.minute_tens   <= 3'd0;
         time_ff.minute_ones   <= 4'd0;
         time_ff.second_tens   <= 3'd0;
         time_ff.second_ones   <= 4'd0;
      end else if (accept) begin
         date_ff <= date_in;
         time_ff <= time_in;
      end
   end

   // response built from the state after this transaction
   always_comb begin
      rsp_in.year_now    = date_in.year;
      rsp_in.month_now   = date_in.month;
      rsp_in.day_now     = date_in.day;
      rsp_in.hour_tens   = time_in.hour_tens;
      rsp_in.hour_ones   = time_in.hour_ones;
      rsp_in.minute_tens = time_in.minute_tens;
      rsp_in.minute_ones = time_in.minute_ones;
      rsp_in.second_tens = time_in.second_tens;
      rsp_in.second_ones = time_in.second_ones;
      rsp_in.status      = status_in;
   end

   ccl_rsp_skid u_rsp_skid (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_data  (rsp_in),
      .in_room  (room),
      .rsp_chan (rsp_chan)
   );

endmodule

>>> rtl/ccl_checker.sv
// port-level checks for the calendar clock and the bind that attaches them
module ccl_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic [2:0]       req_kind,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input ccl_pkg::rsp_type rsp_data
);
   import ccl_pkg::*;

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // every accepted request shows a response the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted request gave no response");

   // an empty response side always takes requests
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty response buffer");

   // ticks and reads are never rejected when they go straight out
   a_tick_read_ok: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid &&
      (req_kind == KIND_TICK || req_kind == KIND_READ || req_kind > KIND_READ)
      |=> rsp_data.status == STATUS_OK)
      else $error("tick or read reported a rejection");

endmodule

bind calendar_clock_with_leap_years ccl_checker u_ccl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .req_kind  (req_chan.data.kind),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_data  (rsp_chan.data)
);

>>> tb/calendar_clock_with_leap_years_tb.sv
// self-checking testbench for the gregorian calendar clock
module calendar_clock_with_leap_years_tb;
   import ccl_pkg::*;

   localparam int SECONDS_PER_DAY = 86400;
   // watchdog: cycles with no transaction on either channel
   localparam int IDLE_LIMIT      = 400;
   // cycles to keep watching once the last response is in
   localparam int TAIL_CYCLES     = 8;
   localparam int RANDOM_PHASES   = 4;
   localparam int PHASE_ITEMS     = 400;
   // the spare kind codes behave as a read
   localparam logic [2:0] KIND_SPARE_LO = 3'd5;
   localparam logic [2:0] KIND_SPARE_HI = 3'd7;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type want;
   } vector_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ccl_stream_if #(.payload_type(req_type)) req_bus ();
   ccl_stream_if #(.payload_type(rsp_type)) rsp_bus ();

   calendar_clock_with_leap_years u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always #6 clock = ~clock;

   // predictor state: time of day in seconds and the calendar date
   int          clock_secs;
   logic [15:0] cal_year;
   logic [3:0]  cal_month;
   logic [4:0]  cal_day;

   // responses still owed by the block, oldest first
   rsp_type     awaited_views[$];
   vector_type  directed_rows[$];

   int fault_count = 0;
   int items_sent  = 0;
   int rejections  = 0;
   int rollovers   = 0;
   int idle_cycles = 0;
   // when set, neither side inserts gaps or stalls
   bit calm_phase  = 1'b0;

   function automatic bit leap_year(input logic [15:0] y);
      int yi;
      yi = int'(y);
      if (yi % 400 == 0) return 1'b1;
      if (yi % 100 == 0) return 1'b0;
      return (yi % 4) == 0;
   endfunction

   // only the listed patterns are refused, anything else goes in as given
   function automatic bit date_valid(input logic [15:0] y, input logic [3:0] m,
                                     input logic [4:0] d);
      if ((m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV) &&
          d == 5'd31) return 1'b0;
      if (m == MONTH_FEB && (d == 5'd30 || d == 5'd31)) return 1'b0;
      if (m == MONTH_FEB && d == 5'd29 && !leap_year(y)) return 1'b0;
      return 1'b1;
   endfunction

   function automatic bit time_valid(input logic [4:0] h, input logic [5:0] mi,
                                     input logic [5:0] s);
      return h <= 5'd23 && mi <= 6'd59 && s <= 6'd59;
   endfunction

   // midnight date step; months outside 1 to 12 and february past 29 stay put
   function automatic void advance_day();
      case (cal_month)
         MONTH_JAN, MONTH_MAR, MONTH_MAY, MONTH_JUL, MONTH_AUG, MONTH_OCT,
         MONTH_DEC: begin
            if (cal_day < 5'd31) begin
               cal_day = cal_day + 5'd1;
            end else if (cal_month != MONTH_DEC) begin
               cal_month = cal_month + 4'd1;
               cal_day   = 5'd1;
            end else begin
               cal_month = MONTH_JAN;
               cal_day   = 5'd1;
               cal_year  = cal_year + 16'd1;
            end
         end
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: begin
            if (cal_day < 5'd30) begin
               cal_day = cal_day + 5'd1;
            end else begin
               cal_month = cal_month + 4'd1;
               cal_day   = 5'd1;
            end
         end
         MONTH_FEB: begin
            if (cal_day < 5'd28) begin
               cal_day = cal_day + 5'd1;
            end else if (cal_day == 5'd28 && leap_year(cal_year)) begin
               cal_day = 5'd29;
            end else if (cal_day == 5'd28 || cal_day == 5'd29) begin
               cal_month = MONTH_MAR;
               cal_day   = 5'd1;
            end
         end
         default: ;
      endcase
   endfunction

   // apply one request to the predictor and return the response it implies
   function automatic rsp_type predict_calendar_view(input req_type r);
      rsp_type v;
      int      hh, mm, ss;
      bit      ok, want_date, want_time;
      v        = '0;
      v.status = STATUS_OK;
      case (r.kind)
         KIND_TICK: begin
            if (clock_secs >= SECONDS_PER_DAY - 1) begin
               clock_secs = 0;
               advance_day();
               rollovers++;
            end else begin
               clock_secs++;
            end
         end
         KIND_SET_DATE, KIND_SET_TIME, KIND_SET_BOTH: begin
            want_date = (r.kind != KIND_SET_TIME);
            want_time = (r.kind != KIND_SET_DATE);
            ok = 1'b1;
            if (want_date && !date_valid(r.new_year, r.new_month, r.new_day)) ok = 1'b0;
            if (want_time && !time_valid(r.new_hour, r.new_minute, r.new_second)) ok = 1'b0;
            // a combined set writes nothing unless both halves pass
            if (ok) begin
               if (want_date) begin
                  cal_year  = r.new_year;
                  cal_month = r.new_month;
                  cal_day   = r.new_day;
               end
               if (want_time) begin
                  clock_secs = int'(r.new_hour) * 3600 + int'(r.new_minute) * 60 +
                               int'(r.new_second);
               end
            end else begin
               v.status = STATUS_REJECT;
               rejections++;
            end
         end
         default: ;
      endcase
      hh = clock_secs / 3600;
      mm = (clock_secs % 3600) / 60;
      ss = clock_secs % 60;
      v.year_now    = cal_year;
      v.month_now   = cal_month;
      v.day_now     = cal_day;
      v.hour_tens   = 2'(hh / 10);
      v.hour_ones   = 4'(hh % 10);
      v.minute_tens = 3'(mm / 10);
      v.minute_ones = 4'(mm % 10);
      v.second_tens = 3'(ss / 10);
      v.second_ones = 4'(ss % 10);
      return v;
   endfunction

   // what a read shows straight after reset, 18 june 2022 20:00:00
   function automatic rsp_type reset_view(input logic st);
      rsp_type v;
      v           = '0;
      v.year_now  = RESET_YEAR;
      v.month_now = RESET_MONTH;
      v.day_now   = RESET_DAY;
      v.hour_tens = RESET_HOUR_TENS;
      v.status    = st;
      return v;
   endfunction

   function automatic int draw_gap();
      return calm_phase ? 0 : int'($urandom_range(0, 7));
   endfunction

   // plain years, and multiples of 400, 100 and 4 to hit the leap rules
   function automatic logic [15:0] pick_year();
      case ($urandom_range(0, 3))
         0:       return 16'($urandom_range(0, 65535));
         1:       return 16'(400 * $urandom_range(0, 163));
         2:       return 16'(100 * $urandom_range(0, 655));
         default: return 16'(4 * $urandom_range(0, 16383));
      endcase
   endfunction

   // mostly ticks and sets close to midnight and month end, some noise
   function automatic req_type random_request();
      req_type r;
      int      pick;
      r.new_year   = 16'($urandom_range(0, 65535));
      r.new_month  = 4'($urandom_range(0, 15));
      r.new_day    = 5'($urandom_range(0, 31));
      r.new_hour   = 5'($urandom_range(0, 31));
      r.new_minute = 6'($urandom_range(0, 63));
      r.new_second = 6'($urandom_range(0, 63));
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         r.kind = KIND_TICK;
      end else if (pick < 56) begin
         r.kind       = KIND_SET_TIME;
         r.new_hour   = 5'd23;
         r.new_minute = 6'd59;
         r.new_second = 6'($urandom_range(45, 59));
      end else if (pick < 66) begin
         r.kind      = KIND_SET_DATE;
         r.new_year  = pick_year();
         r.new_month = 4'($urandom_range(1, 12));
         r.new_day   = 5'($urandom_range(26, 31));
      end else if (pick < 74) begin
         r.kind       = KIND_SET_BOTH;
         r.new_year   = pick_year();
         r.new_month  = 4'($urandom_range(1, 12));
         r.new_day    = 5'($urandom_range(26, 31));
         r.new_hour   = 5'd23;
         r.new_minute = 6'd59;
         r.new_second = 6'($urandom_range(50, 59));
      end else if (pick < 80) begin
         r.kind = 3'($urandom_range(KIND_READ, KIND_SPARE_HI));
      end else begin
         // unshaped set requests, many of them refused
         r.kind = 3'($urandom_range(KIND_SET_DATE, KIND_SET_BOTH));
      end
      return r;
   endfunction

   task automatic add_row(input logic [2:0] kind, input logic [15:0] y,
                          input logic [3:0] mo, input logic [4:0] d,
                          input logic [4:0] h, input logic [5:0] mi,
                          input logic [5:0] s, input bit typed, input rsp_type want);
      vector_type row;
      row.req   = '{kind, y, mo, d, h, mi, s};
      row.typed = typed;
      row.want  = want;
      directed_rows.push_back(row);
   endtask

   // one request transaction; the prediction is taken at acceptance
   task automatic send_request(input req_type r, input bit typed, input rsp_type want);
      int      gap;
      rsp_type pred;
      gap = draw_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.data  <= r;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      pred = predict_calendar_view(r);
      awaited_views.push_back(typed ? want : pred);
      items_sent++;
   endtask

   // hold off the sender until every owed response is back
   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (awaited_views.size() != 0);
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s expected %0d actual %0d", name, want, got);
         fault_count++;
      end
   endtask

   task automatic check_view(input rsp_type want, input rsp_type got);
      check_field("year_now",    want.year_now,    got.year_now);
      check_field("month_now",   want.month_now,   got.month_now);
      check_field("day_now",     want.day_now,     got.day_now);
      check_field("hour_tens",   want.hour_tens,   got.hour_tens);
      check_field("hour_ones",   want.hour_ones,   got.hour_ones);
      check_field("minute_tens", want.minute_tens, got.minute_tens);
      check_field("minute_ones", want.minute_ones, got.minute_ones);
      check_field("second_tens", want.second_tens, got.second_tens);
      check_field("second_ones", want.second_ones, got.second_ones);
      check_field("status",      want.status,      got.status);
   endtask

   // response side: random stalls, every accepted transaction checked
   initial begin
      int gap;
      rsp_bus.ready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         gap = draw_gap();
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
         if (awaited_views.size() == 0) begin
            $error("response with no request outstanding");
            fault_count++;
         end else begin
            check_view(awaited_views.pop_front(), rsp_bus.data);
         end
      end
   end

   // watchdog on a stuck handshake
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // stimulus: directed table, then random phases with a drain between them
   initial begin
      // request side idle from time zero
      req_bus.valid = 1'b0;
      req_bus.data  = '0;

      // read-back and refusals straight after reset have known answers
      add_row(KIND_READ,     16'd2022, MONTH_JUN, 5'd18, 5'd0,  6'd0,  6'd0,
              1'b1, reset_view(STATUS_OK));
      add_row(KIND_SET_DATE, 16'd2022, MONTH_APR, 5'd31, 5'd0,  6'd0,  6'd0,
              1'b1, reset_view(STATUS_REJECT));
      add_row(KIND_SET_TIME, 16'd0,    4'd0,      5'd0,  5'd24, 6'd0,  6'd0,
              1'b1, reset_view(STATUS_REJECT));
      add_row(KIND_SET_BOTH, 16'd2022, MONTH_JUN, 5'd18, 5'd23, 6'd60, 6'd0,
              1'b1, reset_view(STATUS_REJECT));
      add_row(KIND_SET_BOTH, 16'd2022, MONTH_FEB, 5'd30, 5'd10, 6'd0,  6'd0,
              1'b1, reset_view(STATUS_REJECT));
      add_row(KIND_SPARE_LO, 16'hffff, 4'd15,     5'd31, 5'd31, 6'd63, 6'd63,
              1'b1, reset_view(STATUS_OK));
      add_row(KIND_SPARE_HI, 16'd0,    4'd0,      5'd0,  5'd0,  6'd0,  6'd0,
              1'b1, reset_view(STATUS_OK));
      add_row(KIND_SET_TIME, 16'd0,    4'd0,      5'd0,  5'd31, 6'd63, 6'd63,
              1'b1, reset_view(STATUS_REJECT));
      // year wrap from 65535 to 0
      add_row(KIND_SET_BOTH, 16'hffff, MONTH_DEC, 5'd31, 5'd23, 6'd59, 6'd59, 1'b0, '0);
      add_row(KIND_TICK,     16'd0,    4'd0,      5'd0,  5'd0,  6'd0,  6'd0,  1'b0, '0);
      // leap by 400
      add_row(KIND_SET_BOTH, 16'd2000, MONTH_FEB, 5'd28, 5'd23, 6'd59, 6'd59, 1'b0, '0);
      add_row(KIND_TICK,     16'd0,    4'd0,      5'd0,  5'd0,  6'd0,  6'd0,  1'b0, '0);
      // century year without leap day
      add_row(KIND_SET_DATE, 16'd1900, MONTH_FEB, 5'd29, 5'd0,  6'd0,  6'd0,  1'b0, '0);
      add_row(KIND_SET_BOTH, 16'd1900, MONTH_FEB, 5'd28, 5'd23, 6'd59, 6'd59, 1'b0, '0);
      add_row(KIND_TICK,     16'd0,    4'd0,      5'd0,  5'd0,  6'd0,  6'd0,  1'b0, '0);
      // leap by 4, out of the 29th into march
      add_row(KIND_SET_DATE, 16'd2024, MONTH_FEB, 5'd29, 5'd0,  6'd0,  6'd0,  1'b0, '0);
      add_row(KIND_SET_TIME, 16'd0,    4'd0,      5'd0,  5'd23, 6'd59, 6'd59, 1'b0, '0);
      add_row(KIND_TICK,     16'd0,    4'd0,      5'd0,  5'd0,  6'd0,  6'd0,  1'b0, '0);
      // end of a thirty-day month
      add_row(KIND_SET_BOTH, 16'd2023, MONTH_APR, 5'd30, 5'd23, 6'd59, 6'd59, 1'b0, '0);
      add_row(KIND_TICK,     16'd0,    4'd0,      5'd0,  5'd0,  6'd0,  6'd0,  1'b0, '0);
      // month outside 1 to 12 holds the date at midnight
      add_row(KIND_SET_BOTH, 16'd2022, 4'd15,     5'd31, 5'd23, 6'd59, 6'd59, 1'b0, '0);
      add_row(KIND_TICK,     16'd0,    4'd0,      5'd0,  5'd0,  6'd0,  6'd0,  1'b0, '0);
      // month zero, day zero, midnight
      add_row(KIND_SET_BOTH, 16'd2022, 4'd0,      5'd0,  5'd0,  6'd0,  6'd0,  1'b0, '0);
      add_row(KIND_TICK,     16'd0,    4'd0,      5'd0,  5'd0,  6'd0,  6'd0,  1'b0, '0);
      // end of a long month
      add_row(KIND_SET_BOTH, 16'd2023, MONTH_JAN, 5'd31, 5'd23, 6'd59, 6'd59, 1'b0, '0);
      add_row(KIND_TICK,     16'd0,    4'd0,      5'd0,  5'd0,  6'd0,  6'd0,  1'b0, '0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      clock_secs = 72000;
      cal_year   = 16'd2022;
      cal_month  = MONTH_JUN;
      cal_day    = 5'd18;

      foreach (directed_rows[i])
         send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
      wait_for_drain();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         // one phase runs flat out on both sides
         calm_phase = (phase == 1);
         for (int n = 0; n < PHASE_ITEMS; n++)
            send_request(random_request(), 1'b0, '0);
         wait_for_drain();
      end
      calm_phase = 1'b0;

      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d requests sent, %0d set requests refused, %0d midnight rollovers",
               items_sent, rejections, rollovers);
      $display("ticks, reads, spare kinds and all set kinds, leap and year-end cases");
      if (fault_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/ccl_pkg.sv
rtl/ccl_stream_if.sv
rtl/ccl_time_next.sv
rtl/ccl_date_next.sv
rtl/ccl_rsp_skid.sv
rtl/calendar_clock_with_leap_years.sv
rtl/ccl_checker.sv
tb/calendar_clock_with_leap_years_tb.sv
